@@ rtl/tlp_pkg.sv @@
// shared types, constants and helpers for the telemetry line parser
`default_nettype none

package tlp_pkg;

    localparam int LINE_BUFFER = 160;
    localparam int VALUE_WIDTH = 16;
    localparam int OUT_W       = 16;
    localparam int NUM_FIELDS  = 10;
    localparam int LEN_W       = $clog2(LINE_BUFFER);
    localparam int IDX_W       = $clog2(NUM_FIELDS + 1);
    localparam int SAT_W       = VALUE_WIDTH + OUT_W;
    localparam int TIMEOUT_W   = 16;

    localparam logic [TIMEOUT_W-1:0] TIMEOUT_RESET = TIMEOUT_W'(500);

    localparam logic OP_BYTE = 1'b0;
    localparam logic OP_TICK = 1'b1;

    localparam logic EV_FRAME     = 1'b0;
    localparam logic EV_LINK_LOST = 1'b1;

    typedef struct packed {
        logic       operation;
        logic [7:0] rx_byte;
    } t_in_item;

    typedef struct packed {
        logic                    event_kind;
        logic signed [OUT_W-1:0] port1_voltage_code;
        logic signed [OUT_W-1:0] port1_current_code;
        logic signed [OUT_W-1:0] port2_voltage_code;
        logic signed [OUT_W-1:0] port2_current_code;
        logic signed [OUT_W-1:0] port3_voltage_code;
        logic signed [OUT_W-1:0] port3_current_code;
        logic signed [OUT_W-1:0] port4_voltage_code;
        logic signed [OUT_W-1:0] port4_current_code;
        logic [3:0]              relay_mask;
        logic [3:0]              overcurrent_mask;
    } t_out_item;

    typedef struct packed {
        logic tick;
        logic frame_ok;
    } t_link_ev;

    function automatic logic signed [OUT_W-1:0] sat_out(
        input logic signed [VALUE_WIDTH-1:0] v
    );
        logic signed [SAT_W-1:0] w;
        logic signed [SAT_W-1:0] hi;
        logic signed [SAT_W-1:0] lo;
        w  = SAT_W'(v);
        hi = {{(VALUE_WIDTH + 1){1'b0}}, {(OUT_W - 1){1'b1}}};
        lo = {{(VALUE_WIDTH + 1){1'b1}}, {(OUT_W - 1){1'b0}}};
        if (w > hi) begin
            sat_out = OUT_W'(hi);
        end else if (w < lo) begin
            sat_out = OUT_W'(lo);
        end else begin
            sat_out = OUT_W'(w);
        end
    endfunction

endpackage

`default_nettype wire

@@ rtl/tlp_parser.sv @@
// byte-serial line parse machine with field value registers
`default_nettype none

module tlp_parser (
    input  wire logic               i_clk,
    input  wire logic               i_rst_n,
    input  wire logic               i_en,
    input  wire logic [7:0]         i_byte,
    output logic                    o_frame_ok,
    output tlp_pkg::t_out_item      o_frame
);

    localparam logic [2:0] PH_HEADER = 3'd0;
    localparam logic [2:0] PH_COMMA  = 3'd1;
    localparam logic [2:0] PH_START  = 3'd2;
    localparam logic [2:0] PH_SIGNED = 3'd3;
    localparam logic [2:0] PH_DIGITS = 3'd4;
    localparam logic [2:0] PH_DONE   = 3'd5;

    localparam int VW   = tlp_pkg::VALUE_WIDTH;
    localparam int M10W = VW + 4;

    localparam logic [tlp_pkg::LEN_W-1:0] LEN_MAX = tlp_pkg::LEN_W'(tlp_pkg::LINE_BUFFER - 1);
    localparam logic [tlp_pkg::IDX_W-1:0] IDX_LAST = tlp_pkg::IDX_W'(tlp_pkg::NUM_FIELDS - 1);
    localparam logic [M10W-1:0]           MAG_LIM  = M10W'(1) << (VW - 1);

    logic [tlp_pkg::LEN_W-1:0] r_len, n_len;
    logic [2:0]                r_phase, n_phase;
    logic [tlp_pkg::IDX_W-1:0] r_idx, n_idx;
    logic [VW-1:0]             r_mag, n_mag;
    logic                      r_neg, n_neg;
    logic                      r_rej, n_rej;

    logic signed [VW-1:0] r_fields [tlp_pkg::NUM_FIELDS];

    logic                      fld_we;
    logic [tlp_pkg::IDX_W-1:0] fld_wa;
    logic signed [VW-1:0]      fin_val;
    logic signed [VW-1:0]      last_val;
    logic                      digit;
    logic                      blank;
    logic                      newline;
    logic [M10W-1:0]           mag10;
    logic                      fin_nl;

    always_comb begin
        digit   = (i_byte >= 8'h30) && (i_byte <= 8'h39);
        blank   = (i_byte == 8'h20) || (i_byte == 8'h09) || (i_byte == 8'h0D) ||
                  (i_byte == 8'h0B) || (i_byte == 8'h0C);
        newline = (i_byte == 8'h0A);
        mag10   = {r_mag, 3'b000} + {1'b0, r_mag, 2'b00} + {r_mag, 1'b0}
                  - {1'b0, r_mag, 2'b00} + M10W'(i_byte[3:0]);
        // saturating magnitude to a signed value
        if (r_neg) begin
            fin_val = -$signed(r_mag);
        end else if (r_mag[VW-1]) begin
            fin_val = {1'b0, {(VW - 1){1'b1}}};
        end else begin
            fin_val = $signed(r_mag);
        end
    end

    always_comb begin
        n_len      = r_len;
        n_phase    = r_phase;
        n_idx      = r_idx;
        n_mag      = r_mag;
        n_neg      = r_neg;
        n_rej      = r_rej;
        fld_we     = 1'b0;
        fld_wa     = r_idx;
        fin_nl     = 1'b0;
        o_frame_ok = 1'b0;
        if (i_en) begin
            if (newline) begin
                fin_nl     = !r_rej && (r_phase == PH_DIGITS) && (r_idx == IDX_LAST);
                o_frame_ok = !r_rej && ((r_phase == PH_DONE) || fin_nl);
                fld_we     = fin_nl;
                n_len      = '0;
                n_phase    = PH_HEADER;
                n_idx      = '0;
                n_mag      = '0;
                n_neg      = 1'b0;
                n_rej      = 1'b0;
            end else if (r_len >= LEN_MAX) begin
                n_len   = '0;
                n_phase = PH_HEADER;
                n_idx   = '0;
                n_mag   = '0;
                n_neg   = 1'b0;
                n_rej   = 1'b0;
            end else begin
                n_len = r_len + 1'b1;
                if (!r_rej && (r_phase != PH_DONE)) begin
                    case (r_phase)
                        PH_DIGITS: begin
                            if (digit) begin
                                n_mag = (mag10 > MAG_LIM) ? VW'(MAG_LIM) : VW'(mag10);
                            end else begin
                                fld_we = 1'b1;
                                n_idx  = r_idx + 1'b1;
                                n_mag  = '0;
                                n_neg  = 1'b0;
                                if (r_idx == IDX_LAST) begin
                                    n_phase = PH_DONE;
                                end else if (i_byte == 8'h2C) begin
                                    n_phase = PH_START;
                                end else begin
                                    n_phase = PH_COMMA;
                                    n_rej   = 1'b1;
                                end
                            end
                        end
                        PH_HEADER: begin
                            if (i_byte == 8'h54) begin
                                n_phase = PH_COMMA;
                            end else begin
                                n_rej = 1'b1;
                            end
                        end
                        PH_COMMA: begin
                            if (i_byte == 8'h2C) begin
                                n_phase = PH_START;
                            end else begin
                                n_rej = 1'b1;
                            end
                        end
                        PH_START: begin
                            if (blank) begin
                                n_phase = PH_START;
                            end else if ((i_byte == 8'h2D) || (i_byte == 8'h2B)) begin
                                n_neg   = (i_byte == 8'h2D);
                                n_phase = PH_SIGNED;
                            end else if (digit) begin
                                n_mag   = VW'(i_byte[3:0]);
                                n_phase = PH_DIGITS;
                            end else begin
                                n_rej = 1'b1;
                            end
                        end
                        PH_SIGNED: begin
                            if (digit) begin
                                n_mag   = VW'(i_byte[3:0]);
                                n_phase = PH_DIGITS;
                            end else begin
                                n_rej = 1'b1;
                            end
                        end
                        default: begin
                            n_rej = 1'b1;
                        end
                    endcase
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_len   <= '0;
            r_phase <= PH_HEADER;
            r_idx   <= '0;
            r_mag   <= '0;
            r_neg   <= 1'b0;
            r_rej   <= 1'b0;
        end else begin
            r_len   <= n_len;
            r_phase <= n_phase;
            r_idx   <= n_idx;
            r_mag   <= n_mag;
            r_neg   <= n_neg;
            r_rej   <= n_rej;
        end
    end

    always_ff @(posedge i_clk) begin
        if (fld_we) begin
            r_fields[fld_wa] <= fin_val;
        end
    end

    // last number may end at the newline itself
    assign last_val = fin_nl ? fin_val : r_fields[IDX_LAST];

    always_comb begin
        o_frame                    = '0;
        o_frame.event_kind         = tlp_pkg::EV_FRAME;
        o_frame.port1_voltage_code = tlp_pkg::sat_out(r_fields[0]);
        o_frame.port1_current_code = tlp_pkg::sat_out(r_fields[1]);
        o_frame.port2_voltage_code = tlp_pkg::sat_out(r_fields[2]);
        o_frame.port2_current_code = tlp_pkg::sat_out(r_fields[3]);
        o_frame.port3_voltage_code = tlp_pkg::sat_out(r_fields[4]);
        o_frame.port3_current_code = tlp_pkg::sat_out(r_fields[5]);
        o_frame.port4_voltage_code = tlp_pkg::sat_out(r_fields[6]);
        o_frame.port4_current_code = tlp_pkg::sat_out(r_fields[7]);
        o_frame.relay_mask         = r_fields[8][3:0];
        o_frame.overcurrent_mask   = last_val[3:0];
    end

endmodule

`default_nettype wire

@@ rtl/tlp_link_watch.sv @@
// silence counter, timeout register and link state
`default_nettype none

module tlp_link_watch (
    input  wire logic                            i_clk,
    input  wire logic                            i_rst_n,
    input  wire logic                            i_cfg_wr_en,
    input  wire logic [tlp_pkg::TIMEOUT_W-1:0]   i_cfg_wr_data,
    input  wire tlp_pkg::t_link_ev               i_ev,
    output logic                                 o_lost
);

    logic [tlp_pkg::TIMEOUT_W-1:0] r_timeout;
    logic [tlp_pkg::TIMEOUT_W-1:0] r_silence, n_silence;
    logic                          r_link_up, n_link_up;

    always_comb begin
        n_silence = r_silence;
        n_link_up = r_link_up;
        o_lost    = 1'b0;
        if (i_ev.tick) begin
            o_lost = r_link_up && (r_silence >= r_timeout);
            if (r_silence != '1) begin
                n_silence = r_silence + 1'b1;
            end
            if (o_lost) begin
                n_link_up = 1'b0;
            end
        end else if (i_ev.frame_ok) begin
            n_silence = '0;
            n_link_up = 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_timeout <= tlp_pkg::TIMEOUT_RESET;
            r_silence <= '0;
            r_link_up <= 1'b0;
        end else begin
            if (i_cfg_wr_en) begin
                r_timeout <= i_cfg_wr_data;
            end
            r_silence <= n_silence;
            r_link_up <= n_link_up;
        end
    end

endmodule

`default_nettype wire

@@ rtl/tlp_out_skid.sv @@
// result register with one skid entry
`default_nettype none

module tlp_out_skid (
    input  wire logic               i_clk,
    input  wire logic               i_rst_n,
    input  wire logic               i_push,
    input  wire tlp_pkg::t_out_item i_item,
    output logic                    o_full,
    output logic                    o_out_valid,
    input  wire logic               i_out_stall,
    output tlp_pkg::t_out_item      o_out_item
);

    logic               r_out_valid;
    logic               r_skid_valid;
    tlp_pkg::t_out_item r_out_item;
    tlp_pkg::t_out_item r_skid_item;
    logic               pop;
    logic               out_free;

    assign pop      = r_out_valid && !i_out_stall;
    assign out_free = !r_out_valid || pop;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid  <= 1'b0;
            r_skid_valid <= 1'b0;
        end else begin
            if (out_free) begin
                r_out_valid  <= r_skid_valid || i_push;
                r_skid_valid <= r_skid_valid && i_push;
            end else begin
                r_skid_valid <= r_skid_valid || i_push;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (out_free) begin
            if (r_skid_valid) begin
                r_out_item <= r_skid_item;
                if (i_push) begin
                    r_skid_item <= i_item;
                end
            end else if (i_push) begin
                r_out_item <= i_item;
            end
        end else if (i_push) begin
            r_skid_item <= i_item;
        end
    end

    assign o_full      = r_skid_valid;
    assign o_out_valid = r_out_valid;
    assign o_out_item  = r_out_item;

endmodule

`default_nettype wire

@@ rtl/telemetry_line_parser.sv @@
// top level: telemetry line parser with link silence watchdog
//
//  channel   direction  handshake                   payload
//  input     in         i_in_valid / o_in_stall     i_in_item  (t_in_item)
//  result    out        o_out_valid / i_out_stall   o_out_item (t_out_item)
//  config    in         i_cfg_wr_en                 i_cfg_wr_data (link timeout)
//
// one item per cycle unless stalled; a result is registered at the edge that accepts its item
// parse state and the silence counter update at the accepting edge
// a one-entry skid keeps input flowing while a result waits; stall rises only when it is full
// synchronous active-low reset; no clearing pass, timeout resets to 500 ticks
`default_nettype none

module telemetry_line_parser (
    input  wire logic                          i_clk,
    input  wire logic                          i_rst_n,
    input  wire logic                          i_in_valid,
    output logic                               o_in_stall,
    input  wire tlp_pkg::t_in_item             i_in_item,
    output logic                               o_out_valid,
    input  wire logic                          i_out_stall,
    output tlp_pkg::t_out_item                 o_out_item,
    input  wire logic                          i_cfg_wr_en,
    input  wire logic [tlp_pkg::TIMEOUT_W-1:0] i_cfg_wr_data
);

    logic               accept;
    logic               frame_ok;
    logic               lost;
    logic               skid_full;
    tlp_pkg::t_out_item frame;
    tlp_pkg::t_out_item result;
    tlp_pkg::t_link_ev  link_ev;

    assign accept = i_in_valid && !skid_full;

    tlp_parser u_parser (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_en       (accept && (i_in_item.operation == tlp_pkg::OP_BYTE)),
        .i_byte     (i_in_item.rx_byte),
        .o_frame_ok (frame_ok),
        .o_frame    (frame)
    );

    assign link_ev.tick     = accept && (i_in_item.operation == tlp_pkg::OP_TICK);
    assign link_ev.frame_ok = frame_ok;

    tlp_link_watch u_link_watch (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_cfg_wr_en   (i_cfg_wr_en),
        .i_cfg_wr_data (i_cfg_wr_data),
        .i_ev          (link_ev),
        .o_lost        (lost)
    );

    always_comb begin
        if (lost) begin
            result            = '0;
            result.event_kind = tlp_pkg::EV_LINK_LOST;
        end else begin
            result = frame;
        end
    end

    tlp_out_skid u_out_skid (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_push      (frame_ok || lost),
        .i_item      (result),
        .o_full      (skid_full),
        .o_out_valid (o_out_valid),
        .i_out_stall (i_out_stall),
        .o_out_item  (o_out_item)
    );

    assign o_in_stall = skid_full;

endmodule

`default_nettype wire

@@ tb/sv/telemetry_line_parser_test.sv @@
// self-checking testbench for the telemetry line parser with its link silence watchdog
`default_nettype none

module telemetry_line_parser_test;
    timeunit 1ns;
    timeprecision 1ps;

    import tlp_pkg::*;

    localparam logic [7:0] CH_NL    = 8'h0A;
    localparam logic [7:0] CH_TAB   = 8'h09;
    localparam logic [7:0] CH_VT    = 8'h0B;
    localparam logic [7:0] CH_FF    = 8'h0C;
    localparam logic [7:0] CH_CR    = 8'h0D;
    localparam logic [7:0] CH_SPACE = 8'h20;
    localparam logic [7:0] CH_PLUS  = 8'h2B;
    localparam logic [7:0] CH_COMMA = 8'h2C;
    localparam logic [7:0] CH_MINUS = 8'h2D;
    localparam logic [7:0] CH_ZERO  = 8'h30;
    localparam logic [7:0] CH_NINE  = 8'h39;
    localparam logic [7:0] CH_T     = 8'h54;
    localparam logic [7:0] CH_NUL   = 8'h00;

    localparam int SAT_LIMIT      = 1 << (VALUE_WIDTH - 1);
    localparam int SILENCE_MAX    = 65535;
    localparam int LONG_HOLD      = 300;
    localparam int WATCHDOG_LIMIT = 2000;
    localparam int MAX_REPORTS    = 10;

    typedef enum logic [2:0] {
        AWAIT_T,
        AWAIT_COMMA,
        AWAIT_NUMBER,
        AFTER_SIGN,
        IN_DIGITS,
        LINE_DONE
    } parse_phase_e;

    class frame_ledger;
        logic [TIMEOUT_W-1:0] timeout_ticks;
        int                   line_len;
        parse_phase_e         phase;
        int                   field_no;
        int                   magnitude;
        int                   fields [NUM_FIELDS];
        bit                   negative;
        bit                   rejected;
        bit                   link_up;
        int                   silence;
        t_out_item            frames_due [$];
        int                   mismatches;
        int                   frames_seen;

        function new();
            timeout_ticks = TIMEOUT_RESET;
            restart_line();
            link_up     = 1'b0;
            silence     = 0;
            mismatches  = 0;
            frames_seen = 0;
            foreach (fields[k]) fields[k] = 0;
        endfunction

        function void set_timeout(logic [TIMEOUT_W-1:0] v);
            timeout_ticks = v;
        endfunction

        function int pending();
            return frames_due.size();
        endfunction

        function void restart_line();
            line_len  = 0;
            phase     = AWAIT_T;
            field_no  = 0;
            magnitude = 0;
            negative  = 1'b0;
            rejected  = 1'b0;
        endfunction

        function bit is_blank(logic [7:0] c);
            return c == CH_SPACE || c == CH_TAB || c == CH_CR || c == CH_VT || c == CH_FF;
        endfunction

        function logic signed [OUT_W-1:0] clamp16(int v);
            if (v > 32767) return 16'sh7FFF;
            if (v < -32768) return 16'sh8000;
            return v[15:0];
        endfunction

        function void close_number();
            int v;
            if (negative) begin
                v = (magnitude > SAT_LIMIT) ? -SAT_LIMIT : -magnitude;
            end else begin
                v = (magnitude > SAT_LIMIT - 1) ? SAT_LIMIT - 1 : magnitude;
            end
            if (field_no < NUM_FIELDS) fields[field_no] = v;
            field_no++;
            magnitude = 0;
            negative  = 1'b0;
            phase     = (field_no >= NUM_FIELDS) ? LINE_DONE : AWAIT_COMMA;
        endfunction

        function void take_char(logic [7:0] c);
            bit digit;
            digit = (c >= CH_ZERO && c <= CH_NINE);
            if (rejected || phase == LINE_DONE) return;
            if (phase == IN_DIGITS) begin
                if (digit) begin
                    magnitude = magnitude * 10 + (int'(c) - int'(CH_ZERO));
                    if (magnitude > SAT_LIMIT) magnitude = SAT_LIMIT;
                    return;
                end
                close_number();
                if (phase == LINE_DONE) return;
            end
            case (phase)
                AWAIT_T: begin
                    if (c == CH_T) phase = AWAIT_COMMA;
                    else rejected = 1'b1;
                end
                AWAIT_COMMA: begin
                    if (c == CH_COMMA) phase = AWAIT_NUMBER;
                    else rejected = 1'b1;
                end
                AWAIT_NUMBER: begin
                    if (!is_blank(c)) begin
                        if (c == CH_MINUS || c == CH_PLUS) begin
                            negative = (c == CH_MINUS);
                            phase    = AFTER_SIGN;
                        end else if (digit) begin
                            magnitude = int'(c) - int'(CH_ZERO);
                            phase     = IN_DIGITS;
                        end else begin
                            rejected = 1'b1;
                        end
                    end
                end
                AFTER_SIGN: begin
                    if (digit) begin
                        magnitude = int'(c) - int'(CH_ZERO);
                        phase     = IN_DIGITS;
                    end else begin
                        rejected = 1'b1;
                    end
                end
                default: rejected = 1'b1;
            endcase
        endfunction

        // one accepted item: byte or tick
        function void note_item(t_in_item it);
            t_out_item r;
            bit        fire;
            bit        complete;
            r = '0;
            if (it.operation == OP_TICK) begin
                fire = link_up && silence >= int'(timeout_ticks);
                if (silence < SILENCE_MAX) silence++;
                if (fire) begin
                    link_up      = 1'b0;
                    r.event_kind = EV_LINK_LOST;
                    frames_due.push_back(r);
                end
                return;
            end
            if (it.rx_byte != CH_NL) begin
                if (line_len >= LINE_BUFFER - 1) begin
                    restart_line();
                end else begin
                    line_len++;
                    take_char(it.rx_byte);
                end
                return;
            end
            if (!rejected && phase == IN_DIGITS && field_no == NUM_FIELDS - 1) close_number();
            complete = !rejected && phase == LINE_DONE;
            restart_line();
            if (complete) begin
                r.event_kind         = EV_FRAME;
                r.port1_voltage_code = clamp16(fields[0]);
                r.port1_current_code = clamp16(fields[1]);
                r.port2_voltage_code = clamp16(fields[2]);
                r.port2_current_code = clamp16(fields[3]);
                r.port3_voltage_code = clamp16(fields[4]);
                r.port3_current_code = clamp16(fields[5]);
                r.port4_voltage_code = clamp16(fields[6]);
                r.port4_current_code = clamp16(fields[7]);
                r.relay_mask         = fields[8][3:0];
                r.overcurrent_mask   = fields[9][3:0];
                silence = 0;
                link_up = 1'b1;
                frames_seen++;
                frames_due.push_back(r);
            end
        endfunction

        function void compare_field(string name, logic signed [31:0] want,
                                    logic signed [31:0] got);
            if (got !== want) begin
                mismatches++;
                if (mismatches <= MAX_REPORTS) begin
                    $display("mismatch on %s: expected %0d, got %0d", name, want, got);
                end
            end
        endfunction

        function void check_frame(t_out_item got);
            t_out_item want;
            if (frames_due.size() == 0) begin
                mismatches++;
                if (mismatches <= MAX_REPORTS) begin
                    $display("result with none expected: kind %0d", got.event_kind);
                end
                return;
            end
            want = frames_due.pop_front();
            compare_field("event_kind", want.event_kind, got.event_kind);
            compare_field("port1_voltage", want.port1_voltage_code, got.port1_voltage_code);
            compare_field("port1_current", want.port1_current_code, got.port1_current_code);
            compare_field("port2_voltage", want.port2_voltage_code, got.port2_voltage_code);
            compare_field("port2_current", want.port2_current_code, got.port2_current_code);
            compare_field("port3_voltage", want.port3_voltage_code, got.port3_voltage_code);
            compare_field("port3_current", want.port3_current_code, got.port3_current_code);
            compare_field("port4_voltage", want.port4_voltage_code, got.port4_voltage_code);
            compare_field("port4_current", want.port4_current_code, got.port4_current_code);
            compare_field("relay_mask", want.relay_mask, got.relay_mask);
            compare_field("overcurrent_mask", want.overcurrent_mask, got.overcurrent_mask);
        endfunction
    endclass

    logic                 clk         = 1'b0;
    logic                 rst_n       = 1'b0;
    logic                 in_valid    = 1'b0;
    t_in_item             in_item     = '0;
    logic                 out_stall   = 1'b0;
    logic                 cfg_wr_en   = 1'b0;
    logic [TIMEOUT_W-1:0] cfg_wr_data = '0;
    logic                 in_stall;
    logic                 out_valid;
    t_out_item            out_item;

    frame_ledger ledger = new();
    bit          no_gaps      = 1'b0;
    bit          hold_req     = 1'b0;
    int          useful       = 0;
    int          cur_timeout  = 500;
    int          quiet_cycles = 0;

    telemetry_line_parser i_dut (
        .i_clk         (clk),
        .i_rst_n       (rst_n),
        .i_in_valid    (in_valid),
        .o_in_stall    (in_stall),
        .i_in_item     (in_item),
        .o_out_valid   (out_valid),
        .i_out_stall   (out_stall),
        .o_out_item    (out_item),
        .i_cfg_wr_en   (cfg_wr_en),
        .i_cfg_wr_data (cfg_wr_data)
    );

    initial begin
        forever #1 clk = ~clk;
    end

    always @(posedge clk) begin
        if (rst_n) begin
            if (out_valid === 1'b1 && out_stall === 1'b0) ledger.check_frame(out_item);
            if (in_valid === 1'b1 && in_stall === 1'b0) ledger.note_item(in_item);
        end
    end

    always @(posedge clk) begin
        if ((in_valid === 1'b1 && in_stall === 1'b0) ||
            (out_valid === 1'b1 && out_stall === 1'b0)) begin
            quiet_cycles <= 0;
        end else if (quiet_cycles >= WATCHDOG_LIMIT) begin
            $display("TEST FAILED");
            $finish;
        end else begin
            quiet_cycles <= quiet_cycles + 1;
        end
    end

    // result side: random stall per result, one long hold-off on request
    initial begin
        int n;
        forever begin
            if (hold_req) begin
                n        = LONG_HOLD;
                hold_req = 1'b0;
            end else begin
                n = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(0, 15);
            end
            if (n > 0) begin
                out_stall <= 1'b1;
                repeat (n) @(negedge clk);
            end
            out_stall <= 1'b0;
            do @(posedge clk); while (!(out_valid === 1'b1 && out_stall === 1'b0));
            @(negedge clk);
        end
    end

    task automatic drive_item(input t_in_item it);
        int gap;
        gap = no_gaps ? 0 : $urandom_range(0, 15);
        if (gap > 0) begin
            in_valid <= 1'b0;
            repeat (gap) @(negedge clk);
        end
        in_valid <= 1'b1;
        in_item  <= it;
        do @(posedge clk); while (in_stall !== 1'b0);
        @(negedge clk);
    endtask

    task automatic send_byte(input logic [7:0] b);
        t_in_item it;
        it.operation = OP_BYTE;
        it.rx_byte   = b;
        drive_item(it);
    endtask

    task automatic send_ticks(input int n);
        t_in_item it;
        for (int k = 0; k < n; k++) begin
            it.operation = OP_TICK;
            it.rx_byte   = $urandom_range(0, 255);
            drive_item(it);
        end
        useful += n;
    endtask

    task automatic send_text(input string s);
        for (int k = 0; k < s.len(); k++) send_byte(s[k]);
    endtask

    task automatic send_line(input string s, input bit counts);
        send_text(s);
        send_byte(CH_NL);
        if (counts) useful += s.len() + 1;
    endtask

    task automatic settle();
        in_valid <= 1'b0;
        @(negedge clk);
        while (ledger.pending() != 0) @(negedge clk);
        repeat (4) @(negedge clk);
    endtask

    task automatic write_timeout(input logic [TIMEOUT_W-1:0] v);
        settle();
        cfg_wr_en   <= 1'b1;
        cfg_wr_data <= v;
        @(negedge clk);
        cfg_wr_en <= 1'b0;
        ledger.set_timeout(v);
        cur_timeout = v;
    endtask

    function automatic string as_text(input logic [7:0] b);
        return $sformatf("%c", b);
    endfunction

    function automatic string pad_text(input string s, input int n);
        while (s.len() < n) s = {s, "z"};
        return s;
    endfunction

    function automatic logic [7:0] blank_char();
        case ($urandom_range(0, 7))
            0: return CH_TAB;
            1: return CH_CR;
            2: return CH_VT;
            3: return CH_FF;
            default: return CH_SPACE;
        endcase
    endfunction

    function automatic string make_number();
        string s;
        int    nb;
        int    digits;
        s  = "";
        nb = ($urandom_range(0, 2) == 0) ? $urandom_range(1, 2) : 0;
        for (int k = 0; k < nb; k++) s = {s, as_text(blank_char())};
        case ($urandom_range(0, 3))
            0: s = {s, "+"};
            1: s = {s, "-"};
            default: ;
        endcase
        case ($urandom_range(0, 9))
            0, 1, 2: s = {s, $sformatf("%0d", $urandom_range(0, 40000))};
            3, 4:    s = {s, $sformatf("%0d", $urandom_range(0, 15))};
            5:       s = {s, $sformatf("%0d", $urandom_range(0, 999))};
            6: begin
                digits = $urandom_range(6, 12);
                for (int k = 0; k < digits; k++) s = {s, $sformatf("%0d", $urandom_range(0, 9))};
            end
            7: s = {s, "000", $sformatf("%0d", $urandom_range(0, 99))};
            8: begin
                case ($urandom_range(0, 4))
                    0: s = {s, "32767"};
                    1: s = {s, "32768"};
                    2: s = {s, "32769"};
                    3: s = {s, "65535"};
                    default: s = {s, "99999"};
                endcase
            end
            default: s = {s, $sformatf("%0d", $urandom_range(0, 9))};
        endcase
        return s;
    endfunction

    function automatic string make_line(input int nfields);
        string s;
        s = "T";
        for (int k = 0; k < nfields; k++) s = {s, ",", make_number()};
        return s;
    endfunction

    function automatic string make_trailer();
        string s;
        int    n;
        s = as_text($urandom_range(32, 47));
        n = $urandom_range(0, 8);
        for (int k = 0; k < n; k++) s = {s, as_text($urandom_range(32, 126))};
        return s;
    endfunction

    task automatic random_traffic(input int target, input bit last);
        string s;
        int    pick;
        int    p;
        int    n;
        int    overlong = 0;
        while (useful < target || (last && ledger.frames_seen < 25)) begin
            pick    = $urandom_range(0, 99);
            no_gaps = ($urandom_range(0, 4) == 0);
            if (pick < 60) begin
                s = make_line(NUM_FIELDS);
                if ($urandom_range(0, 3) == 0) s = {s, make_trailer()};
                send_line(s, 1'b1);
            end else if (pick < 72) begin
                send_ticks($urandom_range(1, 2 * cur_timeout + 4));
            end else if (pick < 82) begin
                s = make_line(NUM_FIELDS);
                p = $urandom_range(0, s.len() - 1);
                if ($urandom_range(0, 1) == 0) s.putc(p, $urandom_range(1, 255));
                else s = s.substr(0, p);
                send_line(s, 1'b0);
            end else if (pick < 88) begin
                n = $urandom_range(1, 12);
                for (int k = 0; k < n; k++) send_byte($urandom_range(0, 255));
                if ($urandom_range(0, 1) == 0) send_byte(CH_NL);
            end else if (pick < 92) begin
                send_line(make_line($urandom_range(0, NUM_FIELDS - 1)), 1'b0);
            end else if (pick < 95) begin
                send_byte(CH_NL);
            end else if (pick < 97 && overlong < 2) begin
                overlong++;
                n = $urandom_range(LINE_BUFFER, LINE_BUFFER + 15);
                for (int k = 0; k < n; k++) send_byte($urandom_range(32, 126));
                send_line(make_line(NUM_FIELDS), 1'b1);
            end else begin
                s = make_line(NUM_FIELDS);
                s = {s.substr(0, 1), as_text(CH_NUL + 8'd1), s.substr(2, s.len() - 1)};
                send_line(s, 1'b0);
            end
        end
        no_gaps = 1'b0;
    endtask

    initial begin
        string base;
        repeat (9) @(negedge clk);
        rst_n <= 1'b1;
        @(negedge clk);

        // directed part, reset timeout of 500
        send_ticks(1);
        send_line("T,1,-2,+3,4,5,6,7,8,9,10", 1'b0);
        send_line("T,-32768,32767,-32769,32768,999999999999,-999999999999,+0,-0,15,-1", 1'b0);
        send_line({"T,", as_text(CH_SPACE), "1,", as_text(CH_TAB), "2,", as_text(CH_CR), "3,",
                   as_text(CH_VT), "4,", as_text(CH_FF), "-5,", as_text(CH_SPACE),
                   as_text(CH_TAB), "+6,7,8,9,0"}, 1'b0);
        send_line("T,1,2,3,4,5,6,7,8,9,10 trailing,text,42", 1'b0);
        send_text("T,0,0,0,0,0,0,0,0,3,12");
        send_byte(CH_NUL);
        send_line("junk", 1'b0);
        send_text("T,1,");
        send_byte(CH_NUL);
        send_line("2,3,4,5,6,7,8,9,10", 1'b0);
        send_line("", 1'b0);
        send_line("t,1,2,3,4,5,6,7,8,9,10", 1'b0);
        send_line("T1,2,3,4,5,6,7,8,9,10", 1'b0);
        send_line("T,-,2,3,4,5,6,7,8,9,10", 1'b0);
        send_line("T,1,,3,4,5,6,7,8,9,10", 1'b0);
        send_line("T,1,2,3,4,5,6,7,8,9", 1'b0);
        send_line("T,1,2,3,4,5,6,7,8,9, ", 1'b0);
        send_ticks(3);
        base = "T,11,-12,13,-14,15,-16,17,-18,5,10 ";
        send_line(pad_text(base, LINE_BUFFER - 1), 1'b0);
        send_line(pad_text(base, LINE_BUFFER), 1'b0);
        send_text(pad_text("q", LINE_BUFFER));
        send_line("T,21,22,23,24,25,26,27,28,1,2", 1'b0);
        no_gaps = 1'b1;
        send_ticks(510);
        no_gaps = 1'b0;

        // short timeout of 1
        write_timeout(16'd1);
        send_line("T,3,3,3,3,3,3,3,3,3,3", 1'b0);
        send_ticks(3);
        send_line("T,4,4,4,4,4,4,4,4,4,4", 1'b0);
        send_ticks(2);

        // longest timeout
        write_timeout(16'hFFFF);
        send_line("T,5,5,5,5,5,5,5,5,5,5", 1'b0);
        no_gaps = 1'b1;
        send_ticks(20);
        no_gaps = 1'b0;
        send_line("T,6,6,6,6,6,6,6,6,6,6", 1'b0);

        useful = 0;
        for (int ph = 0; ph < 4; ph++) begin
            write_timeout($urandom_range(1, 48));
            if (ph == 1) begin
                // receiver holds off while lines keep coming, the block fills up
                hold_req = 1'b1;
                no_gaps  = 1'b1;
                repeat (5) send_line(make_line(NUM_FIELDS), 1'b1);
                no_gaps  = 1'b0;
            end
            random_traffic(100 * (ph + 1), ph == 3);
        end

        settle();
        repeat (8) @(negedge clk);
        if (ledger.mismatches == 0) begin
            $display("TEST PASSED");
        end else begin
            $display("TEST FAILED");
        end
        $finish;
    end

endmodule

`default_nettype wire
